// ===== rtl/osfh_pkg.sv =====
`default_nettype none

package osfh_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int TASK_ID_BITS = 8;

	// only the low id bits that fit the 8-bit task_id field are significant
	localparam int ID_W   = (TASK_ID_BITS < 8) ? TASK_ID_BITS : 8;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic {
		KIND_DOWN = 1'b0,
		KIND_UP   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_ACQUIRED  = 3'd0,
		ST_ALREADY   = 3'd1,
		ST_BLOCKED   = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_HANDOFF   = 3'd4,
		ST_NOT_OWNER = 3'd5,
		ST_FULL      = 3'd6
	} status_t;

	typedef struct packed {
		logic            push;
		logic            pop;
		logic [ID_W-1:0] push_id;
	} wq_cmd_t;

	typedef struct packed {
		logic            empty;
		logic            full;
		logic [ID_W-1:0] head_id;
	} wq_stat_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] woken_task;
		logic [7:0] free_count_now;
		logic [7:0] owner_now;
		logic       owner_valid_now;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/osfh_wait_queue.sv =====
`default_nettype none

module osfh_wait_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  osfh_pkg::wq_cmd_t cmd,
	output osfh_pkg::wq_stat_t stat
);
	import osfh_pkg::*;

	logic [ID_W-1:0]   mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[tail_q] <= cmd.push_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= ptr_next(tail_q);
				fill_q <= fill_q + 1'b1;
			end else if (cmd.pop) begin
				head_q <= ptr_next(head_q);
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign stat.empty   = (fill_q == '0);
	assign stat.full    = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign stat.head_id = mem_q[head_q];

endmodule

`default_nettype wire

// ===== rtl/osfh_ctrl.sv =====
`default_nettype none

module osfh_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire [7:0]           cfg_wdata,
	input  wire                 req_fire,
	input  osfh_pkg::kind_t     req_kind,
	input  wire [osfh_pkg::ID_W-1:0] req_tid,
	input  osfh_pkg::wq_stat_t  wq_stat,
	output osfh_pkg::wq_cmd_t   wq_cmd,
	output osfh_pkg::result_t   res
);
	import osfh_pkg::*;

	logic [7:0]      free_q;
	logic [ID_W-1:0] owner_q;
	logic            owner_valid_q;

	logic [7:0]      free_nxt;
	logic [ID_W-1:0] owner_nxt;
	logic            owner_valid_nxt;
	logic [ID_W-1:0] woken;
	logic            push_c;
	logic            pop_c;
	logic            is_owner;
	status_t         status;

	assign is_owner = owner_valid_q && (owner_q == req_tid);

	always_comb begin
		free_nxt        = free_q;
		owner_nxt       = owner_q;
		owner_valid_nxt = owner_valid_q;
		woken           = '0;
		push_c          = 1'b0;
		pop_c           = 1'b0;
		status          = ST_NOT_OWNER;
		case (req_kind)
			KIND_DOWN: begin
				if (is_owner) begin
					status = ST_ALREADY;
				end else if (free_q != 8'd0) begin
					free_nxt        = free_q - 8'd1;
					owner_nxt       = req_tid;
					owner_valid_nxt = 1'b1;
					status          = ST_ACQUIRED;
				end else if (!wq_stat.full) begin
					push_c = 1'b1;
					status = ST_BLOCKED;
				end else begin
					status = ST_FULL;
				end
			end
			KIND_UP: begin
				if (!is_owner) begin
					status = ST_NOT_OWNER;
				end else if (wq_stat.empty) begin
					if (free_q != 8'hFF) begin
						free_nxt = free_q + 8'd1;
					end
					owner_nxt       = '0;
					owner_valid_nxt = 1'b0;
					status          = ST_RELEASED;
				end else begin
					woken     = wq_stat.head_id;
					pop_c     = 1'b1;
					owner_nxt = wq_stat.head_id;
					status    = ST_HANDOFF;
				end
			end
			default: begin
				status = ST_NOT_OWNER;
			end
		endcase
	end

	assign wq_cmd.push    = req_fire && push_c;
	assign wq_cmd.pop     = req_fire && pop_c;
	assign wq_cmd.push_id = req_tid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q        <= 8'd1;
			owner_q       <= '0;
			owner_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				free_q <= cfg_wdata;
			end else if (req_fire) begin
				free_q <= free_nxt;
			end
			if (req_fire) begin
				owner_q       <= owner_nxt;
				owner_valid_q <= owner_valid_nxt;
			end
		end
	end

	assign res.status          = status;
	assign res.woken_task      = 8'(woken);
	assign res.free_count_now  = free_nxt;
	assign res.owner_now       = 8'(owner_nxt);
	assign res.owner_valid_now = owner_valid_nxt;

endmodule

`default_nettype wire

// ===== rtl/owned_semaphore_fifo_handoff.sv =====
// channel | dir | tdata (low bit up)                          | tuser
// s_      | in  | task_id[7:0]                                | kind
// m_      | out | woken_task, free_count_now, owner_now,      | status
//         |     | owner_valid_now, zero pad to 32             |
// cfg_    | in  | cfg_wdata = initial_count, written on cfg_we | -
//
// One request per cycle sustained while m_ is not stalled; the request passes the input register,
// then decision logic into the result register, which drives m_tvalid.
// Count, owner and wait-queue ends update in the cycle the request leaves the input register.
// arst_n clears the queue and owner and sets the free count to 1.
// A stalled m_ side holds its result; s_ still takes one request into the input register.
`default_nettype none

module owned_semaphore_fifo_handoff (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // task_id
	input  wire [0:0]  s_tuser,   // kind
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [31:0] m_tdata,  // woken_task, free_count_now, owner_now, owner_valid_now
	output logic [2:0] m_tuser    // status
);
	import osfh_pkg::*;

	logic            valid_s1;
	kind_t           kind_s1;
	logic [ID_W-1:0] tid_s1;
	logic            valid_s2;
	result_t         res_s2;
	logic            adv;
	result_t         res_c;
	wq_cmd_t         wq_cmd;
	wq_stat_t        wq_stat;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= kind_t'(s_tuser[0]);
			tid_s1  <= s_tdata[ID_W-1:0];
		end
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	osfh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_fire (adv),
		.req_kind (kind_s1),
		.req_tid  (tid_s1),
		.wq_stat  (wq_stat),
		.wq_cmd   (wq_cmd),
		.res      (res_c)
	);

	osfh_wait_queue u_wq (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (wq_cmd),
		.stat  (wq_stat)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = {7'd0, res_s2.owner_valid_now, res_s2.owner_now,
		res_s2.free_count_now, res_s2.woken_task};

endmodule

`default_nettype wire

// ===== rtl/osfh_checker.sv =====
`default_nettype none

module osfh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire [2:0]  m_tuser
);
	import osfh_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("m_ payload changed while stalled");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_HANDOFF |-> m_tdata[24] && m_tdata[23:16] == m_tdata[7:0])
		else $error("handoff result does not name woken task as owner");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_RELEASED |-> !m_tdata[24] && m_tdata[23:16] == 8'd0)
		else $error("release left an owner");

	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_HANDOFF |-> m_tdata[7:0] == 8'd0)
		else $error("woken task set without handoff");

endmodule

bind owned_semaphore_fifo_handoff osfh_checker u_osfh_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire

// ===== dv/owned_semaphore_fifo_handoff_test.sv =====
`timescale 1ns / 100ps

module owned_semaphore_fifo_handoff_test;
	import osfh_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PLAN_ROWS   = 17;
	localparam int         PHASES      = 6;
	localparam int         PHASE_ITEMS = 150;
	localparam logic [7:0] ID_MASK     = 8'((1 << ID_W) - 1);

	typedef struct {
		bit         load;
		logic [7:0] load_val;
		kind_t      kind;
		logic [7:0] tid;
		int         reps;
		bit         typed;
		result_t    res;
	} plan_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;   // task_id
	logic [0:0]  s_tuser   = 1'b0;    // kind
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;             // woken_task, free_count_now, owner_now, owner_valid_now
	logic [2:0]  m_tuser;             // status

	// semaphore shadow
	logic [7:0] sem_free  = 8'h01;
	logic [7:0] sem_owner = 8'h00;
	logic       sem_owned = 1'b0;
	logic [7:0] waiters[$];

	result_t pending_grants[$];
	int      mismatch_count = 0;
	int      cycle_count    = 0;
	bit      steady_flow    = 1'b0;

	owned_semaphore_fifo_handoff u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	function automatic result_t arbitrate_request(kind_t kind, logic [7:0] tid);
		result_t    r;
		logic [7:0] id;
		logic       holder;
		id = tid & ID_MASK;
		holder = sem_owned && (sem_owner == id);
		r.woken_task = 8'h00;
		if (kind == KIND_DOWN) begin
			if (holder) begin
				r.status = ST_ALREADY;
			end else if (sem_free != 8'h00) begin
				sem_free--;
				sem_owner = id;
				sem_owned = 1'b1;
				r.status = ST_ACQUIRED;
			end else if (waiters.size() < QUEUE_DEPTH) begin
				waiters.push_back(id);
				r.status = ST_BLOCKED;
			end else begin
				r.status = ST_FULL;
			end
		end else begin
			if (!holder) begin
				r.status = ST_NOT_OWNER;
			end else if (waiters.size() == 0) begin
				if (sem_free != 8'hFF)
					sem_free++;
				sem_owner = 8'h00;
				sem_owned = 1'b0;
				r.status = ST_RELEASED;
			end else begin
				r.woken_task = waiters.pop_front();
				sem_owner = r.woken_task;
				r.status = ST_HANDOFF;
			end
		end
		r.free_count_now  = sem_free;
		r.owner_now       = sem_owned ? sem_owner : 8'h00;
		r.owner_valid_now = sem_owned;
		return r;
	endfunction

	task automatic load_count(logic [7:0] value);
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sem_free = value;
	endtask

	task automatic send_request(kind_t kind, logic [7:0] tid, bit typed, result_t given);
		int      gap;
		result_t r;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tid;
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		r = arbitrate_request(kind, tid);
		pending_grants.push_back(typed ? given : r);
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				$error("result transfer with nothing outstanding: tdata 0x%0h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_grants.pop_front();
				check_field("status", 8'(want.status), 8'(m_tuser));
				check_field("woken_task", want.woken_task, m_tdata[7:0]);
				check_field("free_count_now", want.free_count_now, m_tdata[15:8]);
				check_field("owner_now", want.owner_now, m_tdata[23:16]);
				check_field("owner_valid_now", 8'(want.owner_valid_now), 8'(m_tdata[24]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("owned_semaphore_fifo_handoff_test NOT OK");
			$finish;
		end
	end

	initial begin : sink_pacing
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady_flow) begin
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : stimulus
		plan_row_t  plan [PLAN_ROWS];
		int         load_plan [PHASES];
		logic [7:0] pool [4];
		int         down_pct;
		kind_t      kind;
		logic [7:0] tid;
		result_t    none;

		none = '{ST_ACQUIRED, 8'h00, 8'h00, 8'h00, 1'b0};
		plan = '{
			'{1'b0, 8'h00, KIND_UP,   8'h00, 1,  1'b1, '{ST_NOT_OWNER, 8'h00, 8'h01, 8'h00, 1'b0}},
			'{1'b0, 8'h00, KIND_DOWN, 8'hFF, 1,  1'b1, '{ST_ACQUIRED,  8'h00, 8'h00, 8'hFF, 1'b1}},
			'{1'b0, 8'h00, KIND_DOWN, 8'hFF, 1,  1'b1, '{ST_ALREADY,   8'h00, 8'h00, 8'hFF, 1'b1}},
			'{1'b0, 8'h00, KIND_UP,   8'h00, 1,  1'b1, '{ST_NOT_OWNER, 8'h00, 8'h00, 8'hFF, 1'b1}},
			'{1'b0, 8'h00, KIND_DOWN, 8'h00, 1,  1'b1, '{ST_BLOCKED,   8'h00, 8'h00, 8'hFF, 1'b1}},
			'{1'b0, 8'h00, KIND_DOWN, 8'hAA, 1,  1'b1, '{ST_BLOCKED,   8'h00, 8'h00, 8'hFF, 1'b1}},
			'{1'b0, 8'h00, KIND_UP,   8'hFF, 1,  1'b1, '{ST_HANDOFF,   8'h00, 8'h00, 8'h00, 1'b1}},
			'{1'b0, 8'h00, KIND_UP,   8'h00, 1,  1'b1, '{ST_HANDOFF,   8'hAA, 8'h00, 8'hAA, 1'b1}},
			'{1'b0, 8'h00, KIND_UP,   8'hAA, 1,  1'b1, '{ST_RELEASED,  8'h00, 8'h01, 8'h00, 1'b0}},
			'{1'b1, 8'hFF, KIND_DOWN, 8'h01, 1,  1'b1, '{ST_ACQUIRED,  8'h00, 8'hFE, 8'h01, 1'b1}},
			// count saturates: reload to max while still owned, then release
			'{1'b1, 8'hFF, KIND_UP,   8'h01, 1,  1'b1, '{ST_RELEASED,  8'h00, 8'hFF, 8'h00, 1'b0}},
			'{1'b1, 8'h00, KIND_DOWN, 8'h80, 1,  1'b0, none},
			'{1'b0, 8'h00, KIND_UP,   8'h80, 1,  1'b0, none},
			'{1'b1, 8'h01, KIND_DOWN, 8'h7F, 1,  1'b0, none},
			'{1'b0, 8'h00, KIND_UP,   8'h7F, 1,  1'b0, none},
			// same waiter queued over and over until the queue is full
			'{1'b0, 8'h00, KIND_DOWN, 8'h3C, 16, 1'b0, none},
			'{1'b0, 8'h00, KIND_DOWN, 8'h55, 1,  1'b1, '{ST_FULL,      8'h00, 8'h00, 8'h80, 1'b1}}
		};
		load_plan = '{1, 0, 3, 255, 0, 2};
		load_plan[4] = $urandom_range(0, 255);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].load)
				load_count(plan[i].load_val);
			repeat (plan[i].reps)
				send_request(plan[i].kind, plan[i].tid, plan[i].typed, plan[i].res);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			load_count(8'(load_plan[ph]));
			steady_flow = (ph == 2);
			down_pct = $urandom_range(35, 65);
			foreach (pool[j])
				pool[j] = 8'($urandom_range(0, 255));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < down_pct) begin
					kind = KIND_DOWN;
					tid = $urandom_range(1) ? pool[$urandom_range(3)] : 8'($urandom_range(255));
				end else begin
					kind = KIND_UP;
					if (sem_owned && $urandom_range(99) < 75)
						tid = sem_owner;
					else
						tid = $urandom_range(1) ? pool[$urandom_range(3)]
							: 8'($urandom_range(255));
				end
				send_request(kind, tid, 1'b0, none);
			end
		end
		steady_flow = 1'b0;

		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("owned_semaphore_fifo_handoff_test OK");
		else
			$display("owned_semaphore_fifo_handoff_test NOT OK");
		$finish;
	end

endmodule
